// ===== hdl/tiled_texture_run_address_defines.svh =====
// ----------------------------------------------------------------------------
// Tiled texture run address: assertion macros
// Shared property forms used by the checker of the run address unit.
// ----------------------------------------------------------------------------
`ifndef TILED_TEXTURE_RUN_ADDRESS_DEFINES_SVH
`define TILED_TEXTURE_RUN_ADDRESS_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is also checked across reset.
`define TTA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tta_pkg.sv =====
// ----------------------------------------------------------------------------
// Tiled texture run address package
// Payload types, register indexes and widths shared by the run address unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tta_pkg;

  localparam int CoordW  = 13;
  localparam int WidthW  = 14;
  localparam int PitchW  = 18;
  localparam int LogW    = 3;
  localparam int TilesW  = 10;
  localparam int AddrW   = 32;
  localparam int RunW    = 5;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 18;

  // Largest texel size that changes the layout (sixteen bytes).
  localparam logic [LogW-1:0] MaxTexelLog2 = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SURFACE_WIDTH   = 3'd0,
    CFG_TEXEL_BYTES_LOG2 = 3'd1,
    CFG_DEST_ROW_PITCH  = 3'd2,
    CFG_RECT_LEFT       = 3'd3,
    CFG_RECT_TOP        = 3'd4,
    CFG_RECT_WIDTH      = 3'd5,
    CFG_DEST_X          = 3'd6,
    CFG_DEST_Y          = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [CoordW-1:0] row_offset;
    logic [CoordW-1:0] col_offset;
  } in_t;

  typedef struct packed {
    logic [AddrW-1:0] source_offset;
    logic [AddrW-1:0] dest_offset;
    logic [RunW-1:0]  run_bytes;
    logic             run_valid;
  } out_t;

endpackage

`default_nettype wire

// ===== hdl/tta_tile_addr.sv =====
// ----------------------------------------------------------------------------
// Tiled texture run address: tile swizzle
// Maps an absolute texel column and row to its byte offset in a surface
// stored as 32x32 texel tiles with bank and pipe interleaving.
// ----------------------------------------------------------------------------
`default_nettype none

module tta_tile_addr (
  input  wire logic [tta_pkg::WidthW-1:0] x,
  input  wire logic [tta_pkg::WidthW-1:0] y,
  input  wire logic [tta_pkg::LogW-1:0]   sh,
  input  wire logic [tta_pkg::TilesW-1:0] tiles_x,
  output logic      [tta_pkg::AddrW-1:0]  offset
);
  import tta_pkg::*;

  logic [3:0]        tile_shift;
  logic [18:0]       tile_row;
  logic [19:0]       tile_idx;
  logic [AddrW-1:0]  tile;
  logic [8:0]        micro;
  logic [AddrW-1:0]  swz;
  logic [1:0]        bank_hi;
  logic [2:0]        bank;

  always_comb begin
    tile_shift = {1'b0, sh} + 4'd6;
    tile_row   = {9'd0, tiles_x} * {10'd0, y[WidthW-1:5]};
    tile_idx   = {1'b0, tile_row} + {11'd0, x[WidthW-1:5]};
    tile       = ({12'd0, tile_idx} << tile_shift) & 32'h1FFF_FFFF;

    // Texel position inside the 8-wide micro block: four pairs of rows.
    micro = {4'd0, y[2:1], x[2:0]} << sh;

    swz = {27'd0, y[0], 4'd0}
        + ({31'd0, y[3]} << tile_shift)
        + {28'd0, micro[3:0]}
        + (({23'd0, micro[8:4], 4'd0} + tile) << 1);

    bank_hi = {y[3], 1'b0} + x[4:3];
    bank    = {bank_hi, y[4]};

    offset = {20'd0, bank[0], 11'd0}
           + {21'd0, swz[8:6], 8'd0}
           + {24'd0, bank[2:1], 6'd0}
           + {swz[28:9], 12'd0}
           + {26'd0, swz[5:0]};
  end

endmodule

`default_nettype wire

// ===== hdl/tiled_texture_run_address.sv =====
// ----------------------------------------------------------------------------
// Tiled texture run address unit
// Turns a copy run (row and start column inside a source rectangle) into the
// tiled source byte offset, the linear destination byte offset and the run
// length for a detiling copy engine.
// ----------------------------------------------------------------------------
// The unit takes one transaction per clock on the input channel, unless in_stall
// holds it off, and returns exactly one result transaction for each, in order.
// An accepted transaction is captured in the input register, and its result is
// loaded into the result register once that register is empty or being drained;
// it is shown on the output from there and leaves when the output is not
// stalled. Throughput is one run per cycle while the output is not stalled;
// the clock period is set by the path from the input register
// through the two small multipliers (tile row times tiles per row, and
// destination pitch times row) and the offset adders into the result register.
// The two stages advance independently, so an item is taken into an empty
// input register while a finished result still waits to be taken downstream.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the unit is empty.
`default_nettype none

module tiled_texture_run_address (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire tta_pkg::in_t                in_data,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output tta_pkg::out_t                    out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tta_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tta_pkg::CfgDataW-1:0] cfg_data
);
  import tta_pkg::*;

  // Configuration registers.
  logic [WidthW-1:0] surface_width;
  logic [LogW-1:0]   texel_bytes_log2;
  logic [PitchW-1:0] dest_row_pitch;
  logic [CoordW-1:0] rect_left;
  logic [CoordW-1:0] rect_top;
  logic [WidthW-1:0] rect_width;
  logic [CoordW-1:0] dest_x;
  logic [CoordW-1:0] dest_y;

  // Input register and result register with their valid flags.
  logic  in_reg_valid;
  in_t   in_reg;
  logic  res_valid;
  out_t  res;
  out_t  res_next;

  logic  res_load;
  logic  in_load;

  // Datapath signals.
  logic [LogW-1:0]    sh;
  logic [TilesW-1:0]  tiles_x;
  logic [WidthW:0]    sw_round;
  logic               col_ok;
  logic [WidthW-1:0]  x;
  logic [WidthW-1:0]  y;
  logic [RunW-1:0]    run_texels;
  logic [RunW-1:0]    left_in_run;
  logic [WidthW-1:0]  left_in_rect;
  logic [RunW-1:0]    run_len;
  logic [8:0]         run_len_bytes;
  logic [WidthW-1:0]  dcol;
  logic [WidthW-1:0]  drow;
  logic [AddrW-1:0]   dest_col_bytes;
  logic [AddrW-1:0]   dest_row_bytes;
  logic [AddrW-1:0]   src_offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width    <= 14'd1;
      texel_bytes_log2 <= 3'd4;
      dest_row_pitch   <= '0;
      rect_left        <= '0;
      rect_top         <= '0;
      rect_width       <= 14'd1;
      dest_x           <= '0;
      dest_y           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        CFG_SURFACE_WIDTH:    surface_width    <= cfg_data[WidthW-1:0];
        CFG_TEXEL_BYTES_LOG2: texel_bytes_log2 <= cfg_data[LogW-1:0];
        CFG_DEST_ROW_PITCH:   dest_row_pitch   <= cfg_data[PitchW-1:0];
        CFG_RECT_LEFT:        rect_left        <= cfg_data[CoordW-1:0];
        CFG_RECT_TOP:         rect_top         <= cfg_data[CoordW-1:0];
        CFG_RECT_WIDTH:       rect_width       <= cfg_data[WidthW-1:0];
        CFG_DEST_X:           dest_x           <= cfg_data[CoordW-1:0];
        CFG_DEST_Y:           dest_y           <= cfg_data[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // The result register takes a new value when it is empty or being drained;
  // the input register refills whenever it empties into the result register.
  assign res_load  = in_reg_valid && (!res_valid || !out_stall);
  assign in_load   = !in_reg_valid || res_load;
  assign in_stall  = !in_load;
  assign out_valid = res_valid;
  assign out_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (in_load) begin
        in_reg_valid <= in_valid;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_valid) begin
      in_reg <= in_data;
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  // Texel sizes above sixteen bytes behave as sixteen bytes.
  assign sh = (texel_bytes_log2 > MaxTexelLog2) ? MaxTexelLog2 : texel_bytes_log2;

  // Surface width rounded up to whole 32-texel tiles.
  assign sw_round = {1'b0, surface_width} + 15'd31;
  assign tiles_x  = sw_round[WidthW:5];

  assign x = {1'b0, rect_left} + {1'b0, in_reg.col_offset};
  assign y = {1'b0, rect_top} + {1'b0, in_reg.row_offset};

  tta_tile_addr u_tile_addr (
    .x       (x),
    .y       (y),
    .sh      (sh),
    .tiles_x (tiles_x),
    .offset  (src_offset)
  );

  always_comb begin
    col_ok = {1'b0, in_reg.col_offset} < rect_width;

    // A run covers 16 bytes, or 8 bytes when a texel is a single byte, and
    // stops early at the right edge of the rectangle.
    run_texels    = (sh == '0) ? 5'd8 : (5'd16 >> sh);
    left_in_run   = run_texels - (x[RunW-1:0] & (run_texels - 5'd1));
    left_in_rect  = rect_width - {1'b0, in_reg.col_offset};
    run_len       = (left_in_rect < {9'd0, left_in_run}) ? left_in_rect[RunW-1:0]
                                                         : left_in_run;
    run_len_bytes = {4'd0, run_len} << sh;

    // Linear destination: column bytes plus pitch times row.
    dcol           = {1'b0, in_reg.col_offset} + {1'b0, dest_x};
    drow           = {1'b0, in_reg.row_offset} + {1'b0, dest_y};
    dest_col_bytes = {18'd0, dcol} << sh;
    dest_row_bytes = {14'd0, dest_row_pitch} * {18'd0, drow};

    if (col_ok) begin
      res_next.source_offset = src_offset;
      res_next.dest_offset   = dest_col_bytes + dest_row_bytes;
      res_next.run_bytes     = run_len_bytes[RunW-1:0];
      res_next.run_valid     = 1'b1;
    end else begin
      res_next = '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tta_checker.sv =====
// ----------------------------------------------------------------------------
// Tiled texture run address: port checker
// Watches the ports of the run address unit and flags illegal behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tiled_texture_run_address_defines.svh"

module tta_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire tta_pkg::in_t                 in_data,
  input  wire logic                         out_valid,
  input  wire logic                         out_stall,
  input  wire tta_pkg::out_t                out_data,
  input  wire logic                         cfg_valid,
  input  wire logic                         cfg_ready,
  input  wire logic [tta_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [tta_pkg::CfgDataW-1:0] cfg_data
);
  import tta_pkg::*;

  // The unit only holds off input when both internal stages are full and
  // the output is blocked.
  `TTA_ASSERT_NOW(a_stall_only_when_full, in_stall, out_valid && out_stall, "input stalled while output free")

  // A stalled result transaction stays put.
  `TTA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // A run outside the rectangle carries all-zero fields.
  `TTA_ASSERT_NOW(a_invalid_zero, out_valid && !out_data.run_valid, out_data.source_offset == '0 && out_data.dest_offset == '0 && out_data.run_bytes == '0, "invalid run has nonzero fields")

  // Nothing is delivered right after reset.
  `TTA_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid, "result valid after reset")

endmodule

bind tiled_texture_run_address tta_checker u_tta_checker (.*);

`default_nettype wire
